/* src/evf_pkg.sv */
package evf_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_LOG_VAR_CONST   = 3'd0;
  localparam logic [2:0] CFG_PERSISTENCE     = 3'd1;
  localparam logic [2:0] CFG_MAGNITUDE_GAIN  = 3'd2;
  localparam logic [2:0] CFG_SIGN_GAIN       = 3'd3;
  localparam logic [2:0] CFG_MEAN_RETURN     = 3'd4;
  localparam logic [2:0] CFG_INITIAL_LOG_VAR = 3'd5;

  // Result status codes.
  localparam logic [1:0] ST_OK             = 2'd0;
  localparam logic [1:0] ST_BAD_PRICE      = 2'd1;
  localparam logic [1:0] ST_NOT_STATIONARY = 2'd2;

  // Job kinds handed from the front to the back.
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_BAD    = 2'd1;
  localparam logic [1:0] KIND_RETURN = 2'd2;

  // Depth of the job queue between front and back.
  localparam int JOBQ_DEPTH = 2;

  // Fixed-point constants, Q.32 unless stated otherwise.
  localparam logic [63:0] LIM                = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIM            = 64'hFFFF_8000_0000_0000;
  localparam logic [63:0] OUT48              = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [63:0] LN2_Q32            = 64'h0000_0000_B172_17F8;
  localparam logic [63:0] LN2_Q64            = 64'hB172_17F7_D1CF_79AC;
  localparam logic [63:0] LOG2E_Q32          = 64'h0000_0001_7154_7653;
  localparam logic [63:0] SQRT_2_OVER_PI_Q32 = 64'd3426888095;
  localparam logic [63:0] LN_2PI_Q32         = 64'd7893621894;

  typedef struct packed {
    logic [31:0] price;
    logic        series_start;
  } in_t;

  typedef struct packed {
    logic [47:0]        variance;
    logic [47:0]        volatility;
    logic signed [47:0] neg_log_likelihood;
    logic [1:0]         status;
  } out_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        clear;
    logic [31:0] price;
    logic [31:0] prev_price;
  } job_t;

  typedef struct packed {
    logic [31:0] log_var_const;
    logic [31:0] persistence;
    logic [31:0] magnitude_gain;
    logic [31:0] sign_gain;
    logic [31:0] mean_return;
    logic [31:0] initial_log_var;
  } cfg_t;

  // Magnitude of a two's complement word.
  function automatic logic [63:0] mq_abs(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  // Finish a signed Q.32 product from the unsigned 128-bit product of the
  // magnitudes: drop 32 fraction bits, clamp to LIM, then apply the sign.
  function automatic logic [63:0] mq_fin(input logic [127:0] prod, input logic neg);
    logic [63:0] m;
    m = (|prod[127:79]) ? LIM : {16'd0, prod[79:32]};
    return neg ? (64'd0 - m) : m;
  endfunction

endpackage

/* src/egarch_variance_filter.sv */
// Channel  Ports                           Direction  Beat
// in       in_valid, in_stall, in_data     input      one price and series-start flag
// out      out_valid, out_stall, out_data  output     variance, volatility, likelihood, status
// cfg      cfg_wr_en, cfg_index, cfg_data  input      one 32-bit register write
//
// Exponentials dominate a return (three on the first return, four after), each running a
// series of up to 38 terms through a four-pass 64x64 multiplier and a divider.
// The two logarithms run on their own 32x32 squarer.
// Bad prices and series-start-only beats need no arithmetic.
// Reset (synchronous, rst_n low) clears the configuration and all series state.
// A two-entry job queue keeps the input taking beats while the back end works or out stalls.
module egarch_variance_filter import evf_pkg::*; #(
  parameter int FRAC_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t cfg_r;
  logic q_full, q_push, q_pop, q_not_empty;
  job_t q_in, q_out;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_LOG_VAR_CONST:   cfg_r.log_var_const   <= cfg_data;
        CFG_PERSISTENCE:     cfg_r.persistence     <= cfg_data;
        CFG_MAGNITUDE_GAIN:  cfg_r.magnitude_gain  <= cfg_data;
        CFG_SIGN_GAIN:       cfg_r.sign_gain       <= cfg_data;
        CFG_MEAN_RETURN:     cfg_r.mean_return     <= cfg_data;
        CFG_INITIAL_LOG_VAR: cfg_r.initial_log_var <= cfg_data;
        default: ;
      endcase
    end
  end

  evf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_in)
  );

  evf_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_in),
    .pop      (q_pop),
    .pop_data (q_out),
    .full     (q_full),
    .not_empty(q_not_empty)
  );

  evf_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .job_valid(q_not_empty),
    .job      (q_out),
    .job_pop  (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

/* src/evf_mul.sv */
module evf_mul (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         done,
  output logic [127:0] prod
);

  logic [63:0]  a_r, b_r;
  logic [2:0]   ph_r;
  logic         busy_r, done_r;
  logic [63:0]  pp_r;
  logic [1:0]   ps_r;
  logic [127:0] acc_r;
  logic [31:0]  ma, mb;
  logic [127:0] pp_sh;

  // Pick the halves for the partial product of this phase.
  always_comb begin
    case (ph_r)
      3'd0: begin
        ma = a_r[31:0];
        mb = b_r[31:0];
      end
      3'd1: begin
        ma = a_r[31:0];
        mb = b_r[63:32];
      end
      3'd2: begin
        ma = a_r[63:32];
        mb = b_r[31:0];
      end
      default: begin
        ma = a_r[63:32];
        mb = b_r[63:32];
      end
    endcase
  end

  // Align the registered partial product for accumulation.
  always_comb begin
    case (ps_r)
      2'd0:    pp_sh = {64'd0, pp_r};
      2'd1:    pp_sh = {32'd0, pp_r, 32'd0};
      default: pp_sh = {pp_r, 64'd0};
    endcase
  end

  // Four 32x32 partial products, each added in the cycle after it is formed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= 3'd0;
    end else begin
      done_r <= !start && busy_r && (ph_r == 3'd4);
      if (start) begin
        a_r    <= a;
        b_r    <= b;
        acc_r  <= '0;
        ph_r   <= 3'd0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (ph_r != 3'd4) begin
          pp_r <= ma * mb;
          ps_r <= (ph_r == 3'd0) ? 2'd0 : ((ph_r == 3'd3) ? 2'd2 : 2'd1);
        end
        if (ph_r != 3'd0) begin
          acc_r <= acc_r + pp_sh;
        end
        ph_r <= ph_r + 3'd1;
        if (ph_r == 3'd4) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

/* src/evf_log.sv */
module evf_log (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] p,
  output logic        done,
  output logic [36:0] result
);

  logic [31:0] m_r;
  logic [4:0]  k_r;
  logic [31:0] frac_r;
  logic [4:0]  cnt_r;
  logic        busy_r, done_r;
  logic [4:0]  k_s;
  logic [31:0] m0;
  logic [63:0] sq;
  logic [32:0] s;

  // Position of the leading one, and the mantissa normalised to bit 31.
  always_comb begin
    k_s = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (p[i]) k_s = 5'(i);
    end
    m0 = p << (5'd31 - k_s);
  end

  // One fraction bit per square of the mantissa.
  assign sq = m_r * m_r;
  assign s  = sq[63:31];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == 5'd31);
      if (start) begin
        m_r    <= m0;
        k_r    <= k_s;
        frac_r <= '0;
        cnt_r  <= 5'd0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        m_r    <= s[32] ? s[32:1] : s[31:0];
        frac_r <= {frac_r[30:0], s[32]};
        cnt_r  <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done   = done_r;
  assign result = {k_r, frac_r};

endmodule

/* src/evf_exp.sv */
module evf_exp import evf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] x,
  input  logic        of40,
  input  logic        cap48,
  output logic        done,
  output logic [63:0] result
);

  localparam logic [2:0] X_IDLE = 3'd0;
  localparam logic [2:0] X_Y    = 3'd1;
  localparam logic [2:0] X_T    = 3'd2;
  localparam logic [2:0] X_LOOP = 3'd3;
  localparam logic [2:0] X_MUL  = 3'd4;
  localparam logic [2:0] X_DIV  = 3'd5;
  localparam logic [2:0] X_OUT  = 3'd6;

  logic [2:0]   st_r;
  logic         iss_r, done_r;
  logic [63:0]  x_r, y_r, t_r, sum_r, term_r, dq_r, res_r;
  logic         of40_r, cap48_r;
  logic [5:0]   k_r, rem_r;
  logic [2:0]   dcnt_r;
  logic         mul_start, mul_done;
  logic [63:0]  mul_a, mul_b;
  logic [127:0] mul_prod;
  logic [6:0]   drem;
  logic [63:0]  dq;
  logic [33:0]  sh;
  logic [5:0]   nsh;
  logic [63:0]  mant, capv, rv;

  evf_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .prod (mul_prod)
  );

  // Multiplier operands for each step.
  always_comb begin
    case (st_r)
      X_Y: begin
        mul_a = mq_abs(x_r);
        mul_b = LOG2E_Q32;
      end
      X_T: begin
        mul_a = {32'd0, y_r[31:0]};
        mul_b = LN2_Q64;
      end
      default: begin
        mul_a = term_r;
        mul_b = t_r;
      end
    endcase
  end

  assign mul_start = !iss_r && (st_r == X_Y || st_r == X_T || st_r == X_MUL);

  // Eight quotient bits a cycle of the division by the series index.
  always_comb begin
    drem = {1'b0, rem_r};
    dq   = dq_r;
    for (int j = 0; j < 8; j++) begin
      drem = {drem[5:0], dq[63]};
      dq   = {dq[62:0], 1'b0};
      if (drem >= {1'b0, k_r}) begin
        drem  = drem - {1'b0, k_r};
        dq[0] = 1'b1;
      end
    end
  end

  // Scale the mantissa 2^f by the integer part of the exponent.
  always_comb begin
    sh   = {{2{y_r[63]}}, y_r[63:32]} + (of40_r ? 34'd40 : 34'd32) - 34'd63;
    nsh  = 6'(34'd0 - sh);
    mant = {1'b1, sum_r[63:1]};
    capv = cap48_r ? OUT48 : LIM;
    if (!sh[33] && sh != 34'd0) begin
      rv = capv;
    end else if (sh == 34'd0) begin
      rv = mant;
    end else if ($signed(sh) <= -34'sd64) begin
      rv = 64'd0;
    end else begin
      rv = mant >> nsh;
    end
    if (rv > capv) rv = capv;
  end

  // Sequencer: y = x*log2(e), t = frac*ln2, then the series for 2^frac.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= X_IDLE;
      iss_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= (st_r == X_OUT);
      case (st_r)
        X_IDLE: begin
          if (start) begin
            x_r     <= x;
            of40_r  <= of40;
            cap48_r <= cap48;
            iss_r   <= 1'b0;
            st_r    <= X_Y;
          end
        end
        X_Y: begin
          if (!iss_r) begin
            iss_r <= 1'b1;
          end else if (mul_done) begin
            iss_r <= 1'b0;
            y_r   <= mq_fin(mul_prod, x_r[63]);
            st_r  <= X_T;
          end
        end
        X_T: begin
          if (!iss_r) begin
            iss_r <= 1'b1;
          end else if (mul_done) begin
            iss_r  <= 1'b0;
            t_r    <= mul_prod[95:32];
            sum_r  <= mul_prod[95:32];
            term_r <= mul_prod[95:32];
            k_r    <= 6'd2;
            st_r   <= X_LOOP;
          end
        end
        X_LOOP: begin
          st_r <= (term_r == 64'd0 || k_r == 6'd40) ? X_OUT : X_MUL;
        end
        X_MUL: begin
          if (!iss_r) begin
            iss_r <= 1'b1;
          end else if (mul_done) begin
            iss_r  <= 1'b0;
            dq_r   <= mul_prod[127:64];
            rem_r  <= 6'd0;
            dcnt_r <= 3'd0;
            st_r   <= X_DIV;
          end
        end
        X_DIV: begin
          dq_r   <= dq;
          rem_r  <= drem[5:0];
          dcnt_r <= dcnt_r + 3'd1;
          if (dcnt_r == 3'd7) begin
            term_r <= dq;
            sum_r  <= sum_r + dq;
            k_r    <= k_r + 6'd1;
            st_r   <= X_LOOP;
          end
        end
        X_OUT: begin
          res_r <= rv;
          st_r  <= X_IDLE;
        end
        default: st_r <= X_IDLE;
      endcase
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

/* src/evf_fifo.sv */
module evf_fifo import evf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_data,
  input  logic pop,
  output job_t pop_data,
  output logic full,
  output logic not_empty
);

  localparam int PtrW = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;

  job_t            mem_r [JOBQ_DEPTH];
  logic [PtrW-1:0] wr_r, rd_r;
  logic [PtrW:0]   cnt_r;

  // Write, read and occupancy of the job queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        mem_r[wr_r] <= push_data;
        wr_r        <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  assign pop_data  = mem_r[rd_r];
  assign full      = (cnt_r == (PtrW+1)'(JOBQ_DEPTH));
  assign not_empty = (cnt_r != '0);

endmodule

/* src/evf_front.sv */
module evf_front import evf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  input  logic q_full,
  output logic q_push,
  output job_t q_data
);

  logic [31:0] last_price_r, last_price_nxt;
  logic        have_last_r, have_last_nxt;
  logic        failed_r, failed_nxt;
  logic        accept, push_c;
  logic [1:0]  kind_c;

  assign accept = in_valid && !q_full;

  // Classify the beat against the series state, after any series start.
  always_comb begin
    failed_nxt     = failed_r && !in_data.series_start;
    have_last_nxt  = have_last_r && !in_data.series_start;
    last_price_nxt = in_data.series_start ? 32'd0 : last_price_r;
    push_c         = 1'b0;
    kind_c         = KIND_CLEAR;
    if (!failed_nxt) begin
      if (in_data.price == 32'd0) begin
        push_c     = 1'b1;
        kind_c     = KIND_BAD;
        failed_nxt = 1'b1;
      end else if (!have_last_nxt) begin
        push_c         = in_data.series_start;
        kind_c         = KIND_CLEAR;
        last_price_nxt = in_data.price;
        have_last_nxt  = 1'b1;
      end else begin
        push_c         = 1'b1;
        kind_c         = KIND_RETURN;
        last_price_nxt = in_data.price;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_price_r <= 32'd0;
      have_last_r  <= 1'b0;
      failed_r     <= 1'b0;
    end else if (accept) begin
      last_price_r <= last_price_nxt;
      have_last_r  <= have_last_nxt;
      failed_r     <= failed_nxt;
    end
  end

  assign in_stall          = q_full;
  assign q_push            = accept && push_c;
  assign q_data.kind       = kind_c;
  assign q_data.clear      = in_data.series_start;
  assign q_data.price      = in_data.price;
  assign q_data.prev_price = last_price_r;

endmodule

/* src/evf_back.sv */
module evf_back import evf_pkg::*; #(
  parameter int FRAC_BITS = 24
) (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic job_valid,
  input  job_t job,
  output logic job_pop,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int SHIFT     = 32 - FRAC_BITS;
  localparam int NLL_SHIFT = 9;
  localparam logic signed [32:0] ONE_Q = 33'(64'd1 << FRAC_BITS);

  localparam logic [4:0] B_IDLE = 5'd0;
  localparam logic [4:0] B_LOGA = 5'd1;
  localparam logic [4:0] B_LOGB = 5'd2;
  localparam logic [4:0] B_RET  = 5'd3;
  localparam logic [4:0] B_EZ   = 5'd4;
  localparam logic [4:0] B_Z    = 5'd5;
  localparam logic [4:0] B_M1   = 5'd6;
  localparam logic [4:0] B_M2   = 5'd7;
  localparam logic [4:0] B_M3   = 5'd8;
  localparam logic [4:0] B_HACC = 5'd9;
  localparam logic [4:0] B_HSET = 5'd10;
  localparam logic [4:0] B_VAR  = 5'd11;
  localparam logic [4:0] B_VOL  = 5'd12;
  localparam logic [4:0] B_W    = 5'd13;
  localparam logic [4:0] B_EE   = 5'd14;
  localparam logic [4:0] B_Q    = 5'd15;
  localparam logic [4:0] B_NLL  = 5'd16;
  localparam logic [4:0] B_OUT  = 5'd17;

  function automatic logic [63:0] sx32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  // Q.FRAC_BITS register value to Q.32.
  function automatic logic [63:0] up(input logic [31:0] v);
    return sx32(v) << SHIFT;
  endfunction

  // Q.32 to Q.FRAC_BITS, truncated toward zero and saturated to 32 bits.
  function automatic logic [31:0] to_reg(input logic [63:0] v);
    logic [63:0] t;
    t = v[63] ? (64'd0 - ((64'd0 - v) >> SHIFT)) : (v >> SHIFT);
    if ($signed(t) > $signed(64'h0000_0000_7FFF_FFFF)) return 32'h7FFF_FFFF;
    if ($signed(t) < $signed(64'hFFFF_FFFF_8000_0000)) return 32'h8000_0000;
    return t[31:0];
  endfunction

  logic [4:0]   st_r;
  logic         iss_r;
  job_t         job_r;
  logic         have_first_r;
  logic [31:0]  logvar_r, lastres_r, e_r;
  logic [47:0]  nll_r;
  logic [36:0]  la_r;
  logic [63:0]  d_r, s_r, z_r, a1_r, a2_r, a3_r, acc_r, hs_r;
  logic [63:0]  var_r, vol_r, w_r, ee_r, q_r;
  out_t         res_r, out_r;
  logic         out_valid_r;

  logic         log_start, log_done;
  logic [31:0]  log_p;
  logic [36:0]  log_res;
  logic         mul_start, mul_done, mq_neg;
  logic [63:0]  mq_a, mq_b, mres;
  logic [127:0] mul_prod;
  logic         exp_start, exp_done, exp_of40, exp_cap48;
  logic [63:0]  exp_x, exp_res;
  logic         is_log, is_exp, is_mul, op_done;
  logic [63:0]  hp_q, lres_q, e_q, b1_q, mg_q, sg_q, azc;
  logic         nonstat;
  logic [63:0]  tsum, t2, nsum, nclamp;
  logic [63:0]  ret_res;
  logic [31:0]  h_q;
  logic         out_free;

  evf_log u_log (
    .clk   (clk),
    .rst_n (rst_n),
    .start (log_start),
    .p     (log_p),
    .done  (log_done),
    .result(log_res)
  );

  evf_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mul_start),
    .a    (mq_a),
    .b    (mq_b),
    .done (mul_done),
    .prod (mul_prod)
  );

  evf_exp u_exp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (exp_start),
    .x     (exp_x),
    .of40  (exp_of40),
    .cap48 (exp_cap48),
    .done  (exp_done),
    .result(exp_res)
  );

  // Operands in Q.32.
  assign hp_q   = up(logvar_r);
  assign lres_q = up(lastres_r);
  assign e_q    = up(e_r);
  assign b1_q   = up(cfg.persistence);
  assign mg_q   = up(cfg.magnitude_gain);
  assign sg_q   = up(cfg.sign_gain);
  assign azc    = (z_r[63] ? (64'd0 - z_r) : z_r) - SQRT_2_OVER_PI_Q32;
  assign nonstat = ($signed({cfg.persistence[31], cfg.persistence}) >= ONE_Q) ||
                   ($signed({cfg.persistence[31], cfg.persistence}) <= -ONE_Q);

  // Which unit serves the present step.
  assign is_log  = (st_r == B_LOGA) || (st_r == B_LOGB);
  assign is_exp  = (st_r == B_EZ) || (st_r == B_VAR) || (st_r == B_VOL) || (st_r == B_W);
  assign is_mul  = (st_r == B_RET) || (st_r == B_Z) || (st_r == B_M1) || (st_r == B_M2) ||
                   (st_r == B_M3) || (st_r == B_EE) || (st_r == B_Q);
  assign op_done = is_log ? log_done : (is_exp ? exp_done : mul_done);

  assign log_start = !iss_r && is_log;
  assign exp_start = !iss_r && is_exp;
  assign mul_start = !iss_r && is_mul;
  assign log_p     = (st_r == B_LOGA) ? job_r.price : job_r.prev_price;

  // Multiplier operands.
  always_comb begin
    mq_a   = 64'd0;
    mq_b   = 64'd0;
    mq_neg = 1'b0;
    case (st_r)
      B_RET: begin
        mq_a   = mq_abs(d_r);
        mq_b   = LN2_Q32;
        mq_neg = d_r[63];
      end
      B_Z: begin
        mq_a   = mq_abs(lres_q);
        mq_b   = s_r;
        mq_neg = lres_q[63];
      end
      B_M1: begin
        mq_a   = mq_abs(b1_q);
        mq_b   = mq_abs(hp_q);
        mq_neg = b1_q[63] ^ hp_q[63];
      end
      B_M2: begin
        mq_a   = mq_abs(mg_q);
        mq_b   = mq_abs(azc);
        mq_neg = mg_q[63] ^ azc[63];
      end
      B_M3: begin
        mq_a   = mq_abs(sg_q);
        mq_b   = mq_abs(z_r);
        mq_neg = sg_q[63] ^ z_r[63];
      end
      B_EE: begin
        mq_a = mq_abs(e_q);
        mq_b = mq_abs(e_q);
      end
      B_Q: begin
        mq_a = ee_r;
        mq_b = w_r;
      end
      default: ;
    endcase
  end

  assign mres = mq_fin(mul_prod, mq_neg);

  // Exponential unit operands.
  always_comb begin
    exp_x     = 64'd0;
    exp_of40  = 1'b0;
    exp_cap48 = 1'b0;
    case (st_r)
      B_EZ: exp_x = 64'd0 - {hp_q[63], hp_q[63:1]};
      B_VAR: begin
        exp_x     = hs_r;
        exp_of40  = 1'b1;
        exp_cap48 = 1'b1;
      end
      B_VOL: begin
        exp_x     = {hs_r[63], hs_r[63:1]};
        exp_of40  = 1'b1;
        exp_cap48 = 1'b1;
      end
      B_W:     exp_x = 64'd0 - hs_r;
      default: ;
    endcase
  end

  // Residual, new log-variance and likelihood update.
  always_comb begin
    ret_res = mres - up(cfg.mean_return);
    h_q     = to_reg(acc_r);
    tsum    = LN_2PI_Q32 + hs_r + q_r;
    t2      = tsum[63] ? (64'd0 - ((64'd0 - tsum) >> NLL_SHIFT)) : (tsum >> NLL_SHIFT);
    nsum    = {{16{nll_r[47]}}, nll_r} + t2;
    if ($signed(nsum) > $signed(LIM)) begin
      nclamp = LIM;
    end else if ($signed(nsum) < $signed(NEG_LIM)) begin
      nclamp = NEG_LIM;
    end else begin
      nclamp = nsum;
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign job_pop  = (st_r == B_IDLE) && job_valid;

  // Step sequencer for one job.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= B_IDLE;
      iss_r        <= 1'b0;
      have_first_r <= 1'b0;
      logvar_r     <= 32'd0;
      lastres_r    <= 32'd0;
      nll_r        <= 48'd0;
      out_valid_r  <= 1'b0;
    end else begin
      // Output register: loaded from a finished job, emptied when taken.
      if (st_r == B_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (is_log || is_exp || is_mul) begin
        if (!iss_r) begin
          iss_r <= 1'b1;
        end else if (op_done) begin
          iss_r <= 1'b0;
        end
      end
      case (st_r)
        B_IDLE: begin
          if (job_valid) begin
            job_r <= job;
            if (job.clear) begin
              have_first_r <= 1'b0;
              logvar_r     <= 32'd0;
              lastres_r    <= 32'd0;
              nll_r        <= 48'd0;
            end
            case (job.kind)
              KIND_BAD: begin
                res_r <= '{variance: 48'd0, volatility: 48'd0,
                           neg_log_likelihood: 48'sd0, status: ST_BAD_PRICE};
                st_r  <= B_OUT;
              end
              KIND_RETURN: st_r <= B_LOGA;
              default:     st_r <= B_IDLE;
            endcase
          end
        end
        B_LOGA: begin
          if (iss_r && op_done) begin
            la_r <= log_res;
            st_r <= B_LOGB;
          end
        end
        B_LOGB: begin
          if (iss_r && op_done) begin
            d_r  <= {27'd0, la_r} - {27'd0, log_res};
            st_r <= B_RET;
          end
        end
        B_RET: begin
          if (iss_r && op_done) begin
            e_r <= to_reg(ret_res);
            if (have_first_r) begin
              st_r <= B_EZ;
            end else begin
              acc_r <= up(cfg.initial_log_var);
              st_r  <= B_HSET;
            end
          end
        end
        B_EZ: begin
          if (iss_r && op_done) begin
            s_r  <= exp_res;
            st_r <= B_Z;
          end
        end
        B_Z: begin
          if (iss_r && op_done) begin
            z_r  <= mres;
            st_r <= B_M1;
          end
        end
        B_M1: begin
          if (iss_r && op_done) begin
            a1_r <= mres;
            st_r <= B_M2;
          end
        end
        B_M2: begin
          if (iss_r && op_done) begin
            a2_r <= mres;
            st_r <= B_M3;
          end
        end
        B_M3: begin
          if (iss_r && op_done) begin
            a3_r <= mres;
            st_r <= B_HACC;
          end
        end
        B_HACC: begin
          acc_r <= up(cfg.log_var_const) + a1_r + a2_r + a3_r;
          st_r  <= B_HSET;
        end
        B_HSET: begin
          logvar_r     <= h_q;
          lastres_r    <= e_r;
          have_first_r <= 1'b1;
          hs_r         <= up(h_q);
          st_r         <= B_VAR;
        end
        B_VAR: begin
          if (iss_r && op_done) begin
            var_r <= exp_res;
            st_r  <= B_VOL;
          end
        end
        B_VOL: begin
          if (iss_r && op_done) begin
            vol_r <= exp_res;
            st_r  <= B_W;
          end
        end
        B_W: begin
          if (iss_r && op_done) begin
            w_r  <= exp_res;
            st_r <= B_EE;
          end
        end
        B_EE: begin
          if (iss_r && op_done) begin
            ee_r <= mres;
            st_r <= B_Q;
          end
        end
        B_Q: begin
          if (iss_r && op_done) begin
            q_r  <= mres;
            st_r <= B_NLL;
          end
        end
        B_NLL: begin
          nll_r                    <= nclamp[47:0];
          res_r.variance           <= var_r[47:0];
          res_r.volatility         <= vol_r[47:0];
          res_r.neg_log_likelihood <= nonstat ? LIM[47:0] : nclamp[47:0];
          res_r.status             <= nonstat ? ST_NOT_STATIONARY : ST_OK;
          st_r                     <= B_OUT;
        end
        B_OUT: begin
          if (out_free) begin
            out_r <= res_r;
            st_r  <= B_IDLE;
          end
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A bad-price beat carries no figures.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == ST_BAD_PRICE) |->
      (out_r.variance == 48'd0 && out_r.volatility == 48'd0 &&
       out_r.neg_log_likelihood == 48'sd0))
    else $error("bad-price result carries non-zero figures");

  // A shared unit is started for a single cycle per step.
  assert property (@(posedge clk) disable iff (!rst_n)
    (mul_start || exp_start || log_start) |=> !(mul_start || exp_start || log_start))
    else $error("arithmetic unit started twice in a row");

  // A finished result with a free output register is presented next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_OUT && !out_valid_r) |=> (out_valid_r && st_r == B_IDLE))
    else $error("finished result not presented");

endmodule

/* tb/egarch_variance_filter_checker.sv */
`timescale 1ns / 1ps

// Watches the three ports of the variance filter, predicts every result beat
// from its own copy of the registers and series state, and compares.
module egarch_variance_filter_checker import evf_pkg::*; #(
  parameter int FRAC_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_t         in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_t        out_data,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          mismatches,
  output int          pending
);

  localparam longint SCL     = longint'(1) << (32 - FRAC_BITS);
  localparam longint SAT     = 64'h0000_7FFF_FFFF_FFFF;
  localparam longint LN2     = 64'h0000_0000_B172_17F8;
  localparam logic [63:0] LN2_64 = 64'hB172_17F7_D1CF_79AC;
  localparam longint LOG2E   = 64'h0000_0001_7154_7653;
  localparam longint SQ2PI   = 64'd3426888095;
  localparam longint LN2PI   = 64'd7893621894;
  localparam logic [63:0] MAX48 = 64'h0000_FFFF_FFFF_FFFF;

  // Register copy, indexed by the package register codes.
  logic [31:0] cfg_regs [6];

  // Series state.
  logic [31:0] prev_price;
  logic        have_price, have_return, failed;
  longint      log_var, prev_resid, nll_sum;

  out_t expected_results [$];

  function automatic longint sext32(input logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  // Unsigned product shifted right, saturating to all ones.
  function automatic logic [63:0] prod_shr(input logic [63:0] a, input logic [63:0] b,
                                          input int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    if ((p[127:64] >> s) != 0) return '1;
    return 64'(p >> s);
  endfunction

  function automatic logic [63:0] prod_hi(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[127:64];
  endfunction

  // Signed Q.32 product, truncated toward zero and clamped.
  function automatic longint qmul(input longint a, input longint b);
    logic        neg;
    logic [63:0] ua, ub, m;
    neg = (a < 0) != (b < 0);
    ua  = a < 0 ? 64'd0 - a : a;
    ub  = b < 0 ? 64'd0 - b : b;
    m   = prod_shr(ua, ub, 32);
    if (m > SAT) m = SAT;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint log2_q32(input logic [31:0] p);
    int          k;
    logic [63:0] m, frac;
    k    = 31;
    frac = 0;
    while (p[k] == 1'b0 && k > 0) k--;
    m = 64'(p) << (31 - k);
    for (int i = 0; i < 32; i++) begin
      m    = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        m    = m >> 1;
        frac = frac | 64'd1;
      end
    end
    return longint'((64'(k) << 32) | frac);
  endfunction

  // Fractional power of two as Q1.63.
  function automatic logic [63:0] pow2_frac(input logic [63:0] f);
    logic [63:0] t, total, term;
    t     = prod_shr(f, LN2_64, 32);
    total = t;
    term  = t;
    for (int k = 2; k < 40 && term != 0; k++) begin
      term  = prod_hi(term, t) / 64'(k);
      total = total + term;
    end
    return (64'd1 << 63) | (total >> 1);
  endfunction

  function automatic logic [63:0] exp_q(input longint x, input longint ofrac,
                                       input logic [63:0] cap);
    longint      y, n, sh;
    logic [63:0] f, m, r;
    y  = qmul(x, LOG2E);
    f  = y & 64'hFFFF_FFFF;
    n  = (y - longint'(f)) >>> 32;
    m  = pow2_frac(f);
    sh = n + ofrac - 63;
    if (sh > 0) return cap;
    if (sh == 0) r = m;
    else if (sh <= -64) r = 0;
    else r = m >> (-sh);
    return r > cap ? cap : r;
  endfunction

  function automatic longint to_frac(input longint v);
    longint q;
    q = v / SCL;
    if (q < -longint'(64'h8000_0000)) q = -longint'(64'h8000_0000);
    if (q > longint'(64'h7FFF_FFFF)) q = 64'h7FFF_FFFF;
    return q;
  endfunction

  task automatic clear_series();
    prev_price  = 0;
    have_price  = 0;
    have_return = 0;
    log_var     = 0;
    prev_resid  = 0;
    nll_sum     = 0;
    failed      = 0;
  endtask

  // Advance the series by one accepted input beat; queue any result it causes.
  task automatic predict_variance(input in_t beat);
    longint r, e, h, hp, z, az, acc, q, term, b1, nll_out;
    logic [1:0] st;
    out_t res;
    st = ST_OK;
    if (beat.series_start) clear_series();
    if (failed) return;
    if (beat.price == 0) begin
      failed = 1;
      res = '{variance: '0, volatility: '0, neg_log_likelihood: '0, status: ST_BAD_PRICE};
      expected_results = {expected_results, res};
      return;
    end
    if (!have_price) begin
      prev_price = beat.price;
      have_price = 1;
      return;
    end
    b1 = sext32(cfg_regs[CFG_PERSISTENCE]);
    if (b1 >= (longint'(1) << FRAC_BITS) || b1 <= -(longint'(1) << FRAC_BITS))
      st = ST_NOT_STATIONARY;
    r = qmul(log2_q32(beat.price) - log2_q32(prev_price), LN2);
    prev_price = beat.price;
    e = to_frac(r - sext32(cfg_regs[CFG_MEAN_RETURN]) * SCL) * SCL;
    if (!have_return) begin
      h = sext32(cfg_regs[CFG_INITIAL_LOG_VAR]);
      have_return = 1;
    end else begin
      hp  = log_var * SCL;
      z   = qmul(prev_resid * SCL, longint'(exp_q(-hp / 2, 32, SAT)));
      az  = z < 0 ? -z : z;
      acc = sext32(cfg_regs[CFG_LOG_VAR_CONST]) * SCL + qmul(b1 * SCL, hp)
          + qmul(sext32(cfg_regs[CFG_MAGNITUDE_GAIN]) * SCL, az - SQ2PI)
          + qmul(sext32(cfg_regs[CFG_SIGN_GAIN]) * SCL, z);
      h = to_frac(acc);
    end
    log_var    = h;
    prev_resid = e / SCL;
    h = h * SCL;
    res.variance   = 48'(exp_q(h, 40, MAX48));
    res.volatility = 48'(exp_q(h / 2, 40, MAX48));
    q    = qmul(qmul(e, e), longint'(exp_q(-h, 32, SAT)));
    term = (LN2PI + h + q) / 2;
    nll_sum = nll_sum + term / 256;
    if (nll_sum > SAT) nll_sum = SAT;
    if (nll_sum < -SAT - 1) nll_sum = -SAT - 1;
    nll_out = (st == ST_NOT_STATIONARY) ? SAT : nll_sum;
    res.neg_log_likelihood = 48'(nll_out);
    res.status = st;
    expected_results = {expected_results, res};
  endtask

  // Configuration writes, input beats and result beats, in edge order.
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) cfg_regs[i] = '0;
      clear_series();
      expected_results.delete();
      mismatches <= 0;
    end else begin
      if (cfg_wr_en && cfg_index < 6) cfg_regs[cfg_index] = cfg_data;
      if (in_valid && !in_stall) predict_variance(in_data);
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result beat with none expected: %h", $realtime, out_data);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_results.pop_front();
          if (want !== out_data) begin
            if (mismatches < 10)
              $display("%0t: var %h/%h vol %h/%h nll %h/%h st %0d/%0d (exp/act)",
                       $realtime, want.variance, out_data.variance, want.volatility,
                       out_data.volatility, want.neg_log_likelihood,
                       out_data.neg_log_likelihood, want.status, out_data.status);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
    pending <= expected_results.size();
  end

endmodule

/* tb/tb_egarch_variance_filter.sv */
`timescale 1ns / 1ps

module tb_egarch_variance_filter import evf_pkg::*;;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int          mismatches;
  int          pending;
  int          hold_left = 0;
  logic [31:0] walk_price;

  always #5 clk = ~clk;

  egarch_variance_filter u_dut (.*);

  egarch_variance_filter_checker u_chk (.*);

  // Receiver: after each result beat, stall for a random stretch.
  always @(posedge clk) begin
    int n;
    n = hold_left;
    if (out_valid && !out_stall) n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    else if (n > 0) n--;
    hold_left <= n;
    out_stall <= (n > 0);
  end

  // One input beat, then a random gap, or none when busy.
  task automatic send_price(input logic [31:0] p, input logic start, input bit busy = 0);
    int gap;
    in_valid <= 1'b1;
    in_data  <= '{price: p, series_start: start};
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
    gap = busy ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait until every expected result is back and the block has settled.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_regs(input logic [31:0] c, input logic [31:0] b1,
                            input logic [31:0] ga, input logic [31:0] gs,
                            input logic [31:0] mu, input logic [31:0] h0);
    logic [31:0] vals [6];
    vals = '{c, b1, ga, gs, mu, h0};
    for (int i = 0; i < 6; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // A price random walk with occasional restarts, bad prices and wild jumps.
  task automatic random_prices(input int count);
    int          pick;
    logic [31:0] step;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        walk_price = $urandom_range(1000, 32'h7FFF_FFFF);
        send_price(walk_price, 1'b1);
      end else if (pick < 5) begin
        send_price(32'd0, 1'($urandom_range(0, 1)));
      end else if (pick < 9) begin
        send_price($urandom(), 1'($urandom_range(0, 1)));
      end else begin
        step = walk_price >> $urandom_range(5, 12);
        if ($urandom_range(0, 1)) walk_price = walk_price + step;
        else if (walk_price > step + 1) walk_price = walk_price - step;
        send_price(walk_price, 1'b0, $urandom_range(0, 4) == 0);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: a typical stationary setting.
    write_regs(32'hFFCC_CCCD, 32'h00F3_3333, 32'h0033_3333, 32'hFFE6_0000,
               32'h0000_1000, 32'hFC00_0000);
    send_price(32'd1_000_000, 1'b1);
    send_price(32'd1_010_000, 1'b0);
    send_price(32'd990_000, 1'b0);
    send_price(32'hFFFF_FFFF, 1'b0);
    send_price(32'd1, 1'b0);
    send_price(32'd1, 1'b0);
    send_price(32'd2, 1'b0);
    send_price(32'd0, 1'b0);
    send_price(32'd500, 1'b0);
    send_price(32'd500, 1'b1);
    send_price(32'd0, 1'b1);
    send_price(32'd0, 1'b1);
    send_price(32'h8000_0000, 1'b1);
    send_price(32'h8000_0001, 1'b0);
    send_price(32'h7FFF_FFFF, 1'b0);
    send_price(32'h5555_5555, 1'b0);
    send_price(32'hAAAA_AAAA, 1'b0);
    drain();

    // Random phases, each under its own register setting.
    walk_price = 32'd1_000_000;
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: write_regs(32'hFFCC_CCCD, 32'h00F3_3333, 32'h0033_3333, 32'hFFE6_0000,
                      32'd0, 32'hFC00_0000);
        1: write_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF);
        2: write_regs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h8000_0000, 32'h8000_0000);
        3: write_regs('0, '0, '0, '0, '0, '0);
        4: write_regs(32'hFFF0_0000, 32'h0100_0000, 32'h0020_0000, 32'h0010_0000,
                      32'h0000_0100, 32'hF800_0000);
        5: write_regs(32'hFFF0_0000, 32'hFF00_0000, 32'h0020_0000, 32'hFFF0_0000,
                      32'hFFFF_FF00, 32'hF000_0000);
        6: write_regs(32'h00FF_FFFF, 32'h00FF_FFFF, 32'hFFE0_0000, 32'h0040_0000,
                      32'd0, 32'h1000_0000);
        default: write_regs($urandom(), $urandom_range(0, 1) ? $urandom() :
                            32'($urandom_range(0, 32'h01FF_FFFF)) - 32'h0100_0000,
                            $urandom(), $urandom(), $urandom(), $urandom());
      endcase
      random_prices(133);
      drain();
    end

    if (mismatches == 0 && pending == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #400_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
